// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the ring log head recovery block.
// Each macro checks a property on the rising clock edge outside of reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent holds in a cycle, so the consequent holds in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent holds in a cycle, so the consequent holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rlhr_pkg.sv =====
// Package for the ring log head recovery block: request and result types,
// result source codes and fixed constants. No dependencies.
`timescale 1ns / 1ps

package rlhr_pkg;

    localparam int unsigned SlotWidth  = 16;
    localparam int unsigned CountWidth = 32;

    localparam logic [SlotWidth-1:0]  SlotCountReset = 16'd500;
    localparam logic [CountWidth-1:0] WrapLimit      = 32'h8000_0000;

    typedef enum logic [1:0] {
        FOUND_PARTIAL = 2'd0,
        FOUND_WRAP    = 2'd1,
        FOUND_NONE    = 2'd2
    } t_found_by;

    typedef struct packed {
        logic [CountWidth-1:0] seq_count;
        logic                  readable;
    } t_req;

    typedef struct packed {
        logic [SlotWidth-1:0]  head_slot;
        logic [CountWidth-1:0] next_count;
        t_found_by             found_by;
    } t_res;

    typedef struct packed {
        logic step;
        logic emit;
    } t_scan_ctl;

endpackage

// ===== rtl/core/rlhr_in_stage.sv =====
// Input register of the ring log head recovery block.
// Holds one request until the scan core consumes it; uses rlhr_pkg.
`timescale 1ns / 1ps

module rlhr_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  rlhr_pkg::t_req i_req,
    input  logic          i_advance,
    output logic          o_full,
    output rlhr_pkg::t_req o_req
);

    logic           r_valid;
    rlhr_pkg::t_req r_req;

    assign o_ready = !r_valid || i_advance;
    assign o_full  = r_valid;
    assign o_req   = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_req <= i_req;
        end
    end

endmodule

// ===== rtl/core/rlhr_scan.sv =====
// Scan core of the ring log head recovery block: slot count register, scan
// state and the combinational wrap test and result selection; uses rlhr_pkg.
`timescale 1ns / 1ps

module rlhr_scan (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rlhr_pkg::SlotWidth-1:0]    i_cfg_wdata,
    input  rlhr_pkg::t_req                    i_req,
    input  rlhr_pkg::t_scan_ctl               i_ctl,
    output logic                              o_emit,
    output rlhr_pkg::t_res                    o_res
);

    logic [rlhr_pkg::SlotWidth-1:0]  r_slot_count;
    logic [rlhr_pkg::SlotWidth-1:0]  r_pos;
    logic [rlhr_pkg::CountWidth-1:0] r_prev;
    logic                            r_wrap_seen;
    logic [rlhr_pkg::SlotWidth-1:0]  r_wrap_slot;
    logic [rlhr_pkg::CountWidth-1:0] r_wrap_next;

    logic [rlhr_pkg::CountWidth-1:0] diff;
    logic [rlhr_pkg::CountWidth-1:0] prev_inc;
    logic [rlhr_pkg::SlotWidth:0]    n_pos;
    logic                            is_wrap;
    logic                            at_end;

    assign diff     = i_req.seq_count - r_prev;
    assign prev_inc = r_prev + 32'd1;
    assign n_pos    = {1'b0, r_pos} + 17'd1;
    assign is_wrap  = (r_pos != '0) && !r_wrap_seen && (diff > rlhr_pkg::WrapLimit);
    assign at_end   = n_pos >= {1'b0, r_slot_count};
    assign o_emit   = !i_req.readable || at_end;

    always_comb begin
        if (!i_req.readable) begin
            o_res.head_slot  = r_pos;
            o_res.next_count = (r_pos == '0) ? '0 : prev_inc;
            o_res.found_by   = rlhr_pkg::FOUND_PARTIAL;
        end else if (is_wrap) begin
            o_res.head_slot  = r_pos;
            o_res.next_count = prev_inc;
            o_res.found_by   = rlhr_pkg::FOUND_WRAP;
        end else if (r_wrap_seen) begin
            o_res.head_slot  = r_wrap_slot;
            o_res.next_count = r_wrap_next;
            o_res.found_by   = rlhr_pkg::FOUND_WRAP;
        end else begin
            o_res.head_slot  = '0;
            o_res.next_count = i_req.seq_count + 32'd1;
            o_res.found_by   = rlhr_pkg::FOUND_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= rlhr_pkg::SlotCountReset;
        end else if (i_cfg_we) begin
            r_slot_count <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_prev      <= '0;
            r_wrap_seen <= 1'b0;
            r_wrap_slot <= '0;
            r_wrap_next <= '0;
        end else if (i_ctl.step) begin
            if (i_ctl.emit) begin
                r_pos       <= '0;
                r_prev      <= '0;
                r_wrap_seen <= 1'b0;
                r_wrap_slot <= '0;
                r_wrap_next <= '0;
            end else begin
                r_pos  <= n_pos[rlhr_pkg::SlotWidth-1:0];
                r_prev <= i_req.seq_count;
                if (is_wrap) begin
                    r_wrap_seen <= 1'b1;
                    r_wrap_slot <= r_pos;
                    r_wrap_next <= prev_inc;
                end
            end
        end
    end

endmodule

// ===== rtl/core/rlhr_out_stage.sv =====
// Result register of the ring log head recovery block.
// Holds one result until the consumer takes it; uses rlhr_pkg.
`timescale 1ns / 1ps

module rlhr_out_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  rlhr_pkg::t_res i_res,
    output logic           o_free,
    output logic           o_valid,
    input  logic           i_ready,
    output rlhr_pkg::t_res o_res
);

    logic           r_valid;
    rlhr_pkg::t_res r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// ===== rtl/core/ring_log_head_recovery.sv =====
// A scan-ending request passes from the input register to the result register.
// Throughput: one request per cycle; the scan core does one compare a cycle.
// Input stalls only while a scan-ending request waits behind an untaken result.
// Reset is synchronous and active low: the scan restarts at slot 0 and the
// slot count returns to 500. Depends on rlhr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ring_log_head_recovery (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rlhr_pkg::SlotWidth-1:0] i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  rlhr_pkg::t_req                 i_in_req,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output rlhr_pkg::t_res                 o_out_res
);

    logic                in_full;
    rlhr_pkg::t_req      held_req;
    logic                emit;
    rlhr_pkg::t_res      scan_res;
    logic                out_free;
    logic                advance;
    rlhr_pkg::t_scan_ctl ctl;

    assign advance  = in_full && (!emit || out_free);
    assign ctl.step = advance;
    assign ctl.emit = emit;

    rlhr_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_req     (i_in_req),
        .i_advance (advance),
        .o_full    (in_full),
        .o_req     (held_req)
    );

    rlhr_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (held_req),
        .i_ctl       (ctl),
        .o_emit      (emit),
        .o_res       (scan_res)
    );

    rlhr_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance && emit),
        .i_res   (scan_res),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (o_out_res)
    );

    `ASSERT_NEXT(a_emit_reaches_out, i_clk, i_rst_n, advance && emit, o_out_valid, "result lost")
    `ASSERT_SAME(a_none_head_zero, i_clk, i_rst_n, o_out_valid && (o_out_res.found_by == rlhr_pkg::FOUND_NONE), o_out_res.head_slot == '0, "no-wrap result with nonzero head")
    `ASSERT_SAME(a_stall_only_full, i_clk, i_rst_n, !o_in_ready, in_full && emit && o_out_valid && !i_out_ready, "input stalled without cause")

endmodule
